@@ src/aes_ctr_pkg.sv @@
// Shared types, constants and byte functions for the AES-256 counter-mode block.
package aes_ctr_pkg;

    localparam int BLOCK_BYTES = 16;
    localparam int ROUNDS      = 14;

    localparam logic [2:0] CFG_KEY_0     = 3'd0;
    localparam logic [2:0] CFG_KEY_1     = 3'd1;
    localparam logic [2:0] CFG_KEY_2     = 3'd2;
    localparam logic [2:0] CFG_KEY_3     = 3'd3;
    localparam logic [2:0] CFG_COUNT_HI  = 3'd4;
    localparam logic [2:0] CFG_COUNT_LO  = 3'd5;

    typedef struct packed {
        logic [63:0] data_high;
        logic [63:0] data_low;
        logic [4:0]  byte_count;
        logic        first;
    } in_word_t;

    typedef struct packed {
        logic [63:0] out_high;
        logic [63:0] out_low;
        logic [4:0]  out_count;
    } out_word_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       round_en;
        logic       final_round;
        logic       out_load;
        logic [3:0] rnd;
    } cmd_t;

    localparam logic [0:255][7:0] SBOX = {
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    localparam logic [0:7][7:0] RCON = {
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

endpackage

@@ src/aes_ctr_ctrl.sv @@
// Controller: sequences load and fourteen cipher rounds, and owns the result valid flag.
module aes_ctr_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output aes_ctr_pkg::cmd_t   cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] rnd_reg, rnd_next;
    logic       m_valid_reg, m_valid_next;
    logic       last;
    logic       out_free;

    assign last     = (rnd_reg == 4'(aes_ctr_pkg::ROUNDS));
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next       = state_reg;
        rnd_next         = rnd_reg;
        cmd.load         = 1'b0;
        cmd.round_en     = 1'b0;
        cmd.final_round  = last;
        cmd.out_load     = 1'b0;
        cmd.rnd          = rnd_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    rnd_next   = 4'd1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (!last) begin
                    cmd.round_en = 1'b1;
                    rnd_next     = rnd_reg + 4'd1;
                end else if (out_free) begin
                    // The final round writes the result register directly.
                    cmd.round_en = 1'b1;
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        m_valid_next = cmd.out_load || (m_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rnd_reg     <= 4'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rnd_reg     <= rnd_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

@@ src/aes_ctr_dp.sv @@
// Datapath: configuration registers, counter, AES round and on-the-fly key schedule.
module aes_ctr_dp (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [2:0]             cfg_index,
    input  logic [63:0]            cfg_data,
    input  aes_ctr_pkg::in_word_t  s_data,
    input  aes_ctr_pkg::cmd_t      cmd,
    output aes_ctr_pkg::out_word_t m_data
);

    logic [63:0]  key_reg [0:3];
    logic [63:0]  start_hi_reg, start_lo_reg;
    logic [127:0] ctr_reg, ctr_next;
    logic [127:0] state_reg, state_next;
    logic [31:0]  win_reg [0:7];
    logic [31:0]  win_next [0:7];
    logic [127:0] data_reg;
    logic [4:0]   n_reg;
    logic [4:0]   n_in;
    logic [127:0] blk;
    logic [127:0] sb, sr, mc, rnd_out;
    logic [31:0]  t_word;
    logic [15:0]  keep;
    logic [127:0] masked;
    aes_ctr_pkg::out_word_t out_reg;

    // Configuration writes; indexes beyond the list are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) key_reg[i] <= '0;
            start_hi_reg <= '0;
            start_lo_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                aes_ctr_pkg::CFG_KEY_0:    key_reg[0]   <= cfg_data;
                aes_ctr_pkg::CFG_KEY_1:    key_reg[1]   <= cfg_data;
                aes_ctr_pkg::CFG_KEY_2:    key_reg[2]   <= cfg_data;
                aes_ctr_pkg::CFG_KEY_3:    key_reg[3]   <= cfg_data;
                aes_ctr_pkg::CFG_COUNT_HI: start_hi_reg <= cfg_data;
                aes_ctr_pkg::CFG_COUNT_LO: start_lo_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign n_in = (s_data.byte_count > 5'(aes_ctr_pkg::BLOCK_BYTES))
                  ? 5'(aes_ctr_pkg::BLOCK_BYTES) : s_data.byte_count;
    assign blk  = s_data.first ? {start_hi_reg, start_lo_reg} : ctr_reg;

    // One AES round on the state register.
    always_comb begin
        logic [7:0] a0, a1, a2, a3;
        for (int k = 0; k < 16; k++) begin
            sb[127 - 8*k -: 8] = aes_ctr_pkg::SBOX[state_reg[127 - 8*k -: 8]];
        end
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) begin
                sr[127 - 8*(k + 4*c) -: 8] = sb[127 - 8*(k + 4*((c + k) % 4)) -: 8];
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0 = sr[127 - 32*c -: 8];
            a1 = sr[119 - 32*c -: 8];
            a2 = sr[111 - 32*c -: 8];
            a3 = sr[103 - 32*c -: 8];
            mc[127 - 32*c -: 8] = aes_ctr_pkg::xtime(a0) ^ aes_ctr_pkg::xtime(a1) ^ a1 ^ a2 ^ a3;
            mc[119 - 32*c -: 8] = a0 ^ aes_ctr_pkg::xtime(a1) ^ aes_ctr_pkg::xtime(a2) ^ a2 ^ a3;
            mc[111 - 32*c -: 8] = a0 ^ a1 ^ aes_ctr_pkg::xtime(a2) ^ aes_ctr_pkg::xtime(a3) ^ a3;
            mc[103 - 32*c -: 8] = aes_ctr_pkg::xtime(a0) ^ a0 ^ a1 ^ a2 ^ aes_ctr_pkg::xtime(a3);
        end
        rnd_out = (cmd.final_round ? sr : mc)
                  ^ {win_reg[4], win_reg[5], win_reg[6], win_reg[7]};
    end

    // Key window slides forward four words per round. Odd rounds produce a word
    // index that is a multiple of eight (rotate, substitute, round constant).
    always_comb begin
        if (cmd.rnd[0]) begin
            t_word = aes_ctr_pkg::sub_word({win_reg[7][23:0], win_reg[7][31:24]})
                     ^ {aes_ctr_pkg::RCON[cmd.rnd[3:1]], 24'h0};
        end else begin
            t_word = aes_ctr_pkg::sub_word(win_reg[7]);
        end
        for (int i = 0; i < 4; i++) win_next[i] = win_reg[i + 4];
        win_next[4] = win_reg[0] ^ t_word;
        win_next[5] = win_reg[1] ^ win_next[4];
        win_next[6] = win_reg[2] ^ win_next[5];
        win_next[7] = win_reg[3] ^ win_next[6];
    end

    always_comb begin
        for (int k = 0; k < 16; k++) keep[k] = (5'(k) < n_reg);
        for (int k = 0; k < 16; k++) begin
            masked[127 - 8*k -: 8] = keep[k] ? (data_reg[127 - 8*k -: 8]
                                     ^ rnd_out[127 - 8*k -: 8]) : 8'h00;
        end
    end

    always_comb begin
        state_next = state_reg;
        ctr_next   = ctr_reg;
        if (cmd.load) begin
            state_next = blk ^ {key_reg[0], key_reg[1]};
            ctr_next   = blk + ((n_in == 5'(aes_ctr_pkg::BLOCK_BYTES)) ? 128'd1 : 128'd0);
        end else if (cmd.round_en) begin
            state_next = rnd_out;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctr_reg <= '0;
        end else begin
            ctr_reg <= ctr_next;
        end
    end

    always_ff @(posedge aclk) begin
        state_reg <= state_next;
        if (cmd.load) begin
            data_reg <= {s_data.data_high, s_data.data_low};
            n_reg    <= n_in;
            for (int i = 0; i < 4; i++) begin
                win_reg[2*i]     <= key_reg[i][63:32];
                win_reg[2*i + 1] <= key_reg[i][31:0];
            end
        end else if (cmd.round_en) begin
            for (int i = 0; i < 8; i++) win_reg[i] <= win_next[i];
        end
        if (cmd.out_load) begin
            out_reg.out_high  <= masked[127:64];
            out_reg.out_low   <= masked[63:0];
            out_reg.out_count <= n_reg;
        end
    end

    assign m_data = out_reg;

endmodule

@@ src/aes256_ctr_keystream_xor.sv @@
// Top level of the AES-256 counter-mode keystream XOR block.
// Each accepted word is one 16-byte block; it is XORed with AES-256 of the
// running counter block and bytes past the valid count come out as zero. The
// accepting edge loads the counter and applies the first round key. The single
// round unit then runs the fourteen rounds on the following edges, one per
// cycle unless the last round stalls, while the key schedule is expanded on
// the fly beside it, so there is no round key storage. The final round writes
// the result register, and no new word is accepted while the rounds of the
// previous one are still running. A new word is accepted as soon as the round
// unit is free, even while the previous result still waits in the output
// register. The last round stalls only if that register is still full. Set
// first on a word to restart from the programmed counter. The counter steps by
// one after every full block. Configuration writes (indexes 0 to 3 key, 4 and
// 5 start counter) are always accepted and must be made while the block is
// idle.
module aes256_ctr_keystream_xor (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [2:0]             cfg_index,
    input  logic [63:0]            cfg_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  aes_ctr_pkg::in_word_t  s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output aes_ctr_pkg::out_word_t m_data
);

    aes_ctr_pkg::cmd_t cmd;

    assign cfg_ready = 1'b1;

    aes_ctr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    aes_ctr_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .cmd       (cmd),
        .m_data    (m_data)
    );

endmodule

@@ tb/tb_aes256_ctr_keystream_xor.sv @@
// Self-checking testbench for the AES-256 counter-mode keystream XOR block.
module tb_aes256_ctr_keystream_xor;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS = 1750;
    localparam int CYCLE_LIMIT  = 400000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    aes_ctr_pkg::in_word_t  s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    aes_ctr_pkg::out_word_t m_data;

    always #5 aclk = ~aclk;

    aes256_ctr_keystream_xor i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // Shadow copy of the configuration and the running counter.
    logic [63:0]  shadow_regs [6];
    logic [127:0] ctr_block;
    logic [7:0]   sbox_tab [256];

    aes_ctr_pkg::out_word_t cipher_queue [$];
    int           error_count = 0;
    int           cycle_count = 0;
    int           words_sent = 0;
    int           words_checked = 0;
    int           cfg_writes = 0;
    int           stall_left = 0;
    bit           quiet_phase = 1'b0;

    function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
        logic [7:0] p;
        p = '0;
        for (int i = 0; i < 8; i++) begin
            if (b[0]) p ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
            b = b >> 1;
        end
        return p;
    endfunction

    // Build the S-box from the field inverse and the affine map.
    function automatic logic [7:0] sbox_calc(logic [7:0] x);
        logic [7:0] r, b;
        r = 8'h01;
        b = x;
        for (int e = 254; e != 0; e = e >> 1) begin
            if (e & 1) r = gmul(r, b);
            b = gmul(b, b);
        end
        return r ^ {r[6:0], r[7]} ^ {r[5:0], r[7:6]} ^ {r[4:0], r[7:5]}
               ^ {r[3:0], r[7:4]} ^ 8'h63;
    endfunction

    function automatic logic [31:0] sub4(logic [31:0] w);
        return {sbox_tab[w[31:24]], sbox_tab[w[23:16]], sbox_tab[w[15:8]],
                sbox_tab[w[7:0]]};
    endfunction

    function automatic logic [127:0] aes256_encrypt(logic [127:0] blk);
        logic [31:0]  w [60];
        logic [31:0]  t;
        logic [7:0]   s [16];
        logic [7:0]   u [16];
        logic [7:0]   rc;
        for (int i = 0; i < 4; i++) begin
            w[2*i]   = shadow_regs[i][63:32];
            w[2*i+1] = shadow_regs[i][31:0];
        end
        rc = 8'h01;
        for (int i = 8; i < 60; i++) begin
            t = w[i-1];
            if (i % 8 == 0) begin
                t = sub4({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                rc = gmul(rc, 8'h02);
            end else if (i % 8 == 4) begin
                t = sub4(t);
            end
            w[i] = w[i-8] ^ t;
        end
        for (int k = 0; k < 16; k++) s[k] = blk[127-8*k -: 8];
        for (int r = 0; r <= 14; r++) begin
            if (r > 0) begin
                for (int k = 0; k < 16; k++) s[k] = sbox_tab[s[k]];
                for (int c = 0; c < 4; c++)
                    for (int k = 0; k < 4; k++) u[k+4*c] = s[k+4*((c+k)%4)];
                for (int c = 0; c < 4; c++) begin
                    if (r < 14) begin
                        s[4*c]   = gmul(u[4*c],2) ^ gmul(u[4*c+1],3) ^ u[4*c+2] ^ u[4*c+3];
                        s[4*c+1] = u[4*c] ^ gmul(u[4*c+1],2) ^ gmul(u[4*c+2],3) ^ u[4*c+3];
                        s[4*c+2] = u[4*c] ^ u[4*c+1] ^ gmul(u[4*c+2],2) ^ gmul(u[4*c+3],3);
                        s[4*c+3] = gmul(u[4*c],3) ^ u[4*c+1] ^ u[4*c+2] ^ gmul(u[4*c+3],2);
                    end else begin
                        for (int k = 0; k < 4; k++) s[4*c+k] = u[4*c+k];
                    end
                end
            end
            for (int c = 0; c < 4; c++)
                for (int k = 0; k < 4; k++) s[4*c+k] ^= w[4*r+c][31-8*k -: 8];
        end
        for (int k = 0; k < 16; k++) blk[127-8*k -: 8] = s[k];
        return blk;
    endfunction

    // Predict the ciphertext word for one accepted block and step the counter.
    function automatic aes_ctr_pkg::out_word_t predict_cipher(aes_ctr_pkg::in_word_t w);
        aes_ctr_pkg::out_word_t o;
        logic [127:0] ks, mask;
        int           n;
        n = (w.byte_count > 16) ? 16 : int'(w.byte_count);
        if (w.first) ctr_block = {shadow_regs[aes_ctr_pkg::CFG_COUNT_HI],
                                  shadow_regs[aes_ctr_pkg::CFG_COUNT_LO]};
        ks = aes256_encrypt(ctr_block);
        mask = (n == 0) ? '0 : ~({128{1'b1}} >> (8 * n));
        {o.out_high, o.out_low} = ({w.data_high, w.data_low} ^ ks) & mask;
        o.out_count = 5'(n);
        if (n == aes_ctr_pkg::BLOCK_BYTES) ctr_block = ctr_block + 128'd1;
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch on %s: got %h, expected %h", what, got, want);
        error_count++;
    endtask

    // Random idle burst, none in the quiet closing part of the run.
    task automatic idle_gap();
        if (!quiet_phase && $urandom_range(3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(10, 1)) @(posedge aclk);
        end
    endtask

    // Leaves cfg_valid high after the accepting edge; the caller drops it.
    task automatic write_cfg(logic [2:0] idx, logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx < 6) shadow_regs[idx] = val;
        cfg_writes++;
    endtask

    // Waits until every result is back, plus the block's latency.
    task automatic drain();
        s_valid <= 1'b0;
        while (cipher_queue.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // Leaves s_valid high after the accepting edge; the next send, an idle
    // burst or a drain decides its value for the following edge.
    task automatic send_block(aes_ctr_pkg::in_word_t w);
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        cipher_queue.push_back(predict_cipher(w));
        words_sent++;
    endtask

    task automatic random_settings(int mode);
        for (int i = 0; i < 6; i++) begin
            logic [63:0] v;
            v = {$urandom, $urandom};
            if (mode == 1) v = '0;
            if (mode == 2) v = '1;
            if (i == aes_ctr_pkg::CFG_COUNT_LO && mode == 0 && $urandom_range(1))
                v = 64'hffff_ffff_ffff_fffe;
            write_cfg(3'(i), v);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic aes_ctr_pkg::in_word_t rand_block();
        aes_ctr_pkg::in_word_t w;
        w.data_high = {$urandom, $urandom};
        w.data_low  = {$urandom, $urandom};
        case ($urandom_range(9))
            0:       w.byte_count = 5'($urandom_range(31));
            1, 2:    w.byte_count = 5'($urandom_range(15, 1));
            default: w.byte_count = 5'(aes_ctr_pkg::BLOCK_BYTES);
        endcase
        w.first = ($urandom_range(15) == 0);
        return w;
    endfunction

    // Directed rows: data high, data low, count, first, typed expectation or not.
    typedef struct {
        logic [63:0] dh, dl;
        logic [4:0]  cnt;
        logic        first;
        bit          has_exp;
        aes_ctr_pkg::out_word_t exp_w;
    } row_t;

    row_t rows [$];

    // Result checker with random back-pressure bursts.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (cipher_queue.size() == 0) begin
                    report_mismatch("unexpected word", m_data.out_high, 64'h0);
                end else begin
                    aes_ctr_pkg::out_word_t e;
                    e = cipher_queue.pop_front();
                    if (m_data.out_high !== e.out_high)
                        report_mismatch("out_high", m_data.out_high, e.out_high);
                    if (m_data.out_low !== e.out_low)
                        report_mismatch("out_low", m_data.out_low, e.out_low);
                    if (m_data.out_count !== e.out_count)
                        report_mismatch("out_count", 64'(m_data.out_count), 64'(e.out_count));
                    words_checked++;
                end
            end
        end
        if (stall_left == 0 && !quiet_phase && $urandom_range(3) == 0)
            stall_left = $urandom_range(10, 1);
        m_ready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        row_t r;
        for (int i = 0; i < 256; i++) sbox_tab[i] = sbox_calc(8'(i));
        for (int i = 0; i < 6; i++) shadow_regs[i] = '0;
        ctr_block = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Zero key and counter: the first keystream block is the well-known
        // AES-256 encryption of an all-zero block.
        r = '{64'h0, 64'h0, 5'd16, 1'b1, 1'b1,
              '{64'hdc95c078a2408989, 64'had48a21492842087, 5'd16}};
        rows.push_back(r);
        // A count of zero gives an all-zero result.
        r = '{'1, '1, 5'd0, 1'b0, 1'b1, '{64'h0, 64'h0, 5'd0}};
        rows.push_back(r);
        r = '{'1, '1, 5'd31, 1'b0, 1'b0, '0}; rows.push_back(r);
        r = '{'1, '1, 5'd17, 1'b0, 1'b0, '0}; rows.push_back(r);
        for (int n = 1; n <= 16; n++) begin
            r = '{64'h0123456789abcdef, 64'hfedcba9876543210, 5'(n), 1'b0, 1'b0, '0};
            rows.push_back(r);
        end
        r = '{'1, '0, 5'd8, 1'b1, 1'b0, '0}; rows.push_back(r);
        r = '{'0, '1, 5'd16, 1'b0, 1'b0, '0}; rows.push_back(r);

        foreach (rows[i]) begin
            aes_ctr_pkg::in_word_t w;
            w = '{rows[i].dh, rows[i].dl, rows[i].cnt, rows[i].first};
            send_block(w);
            if (rows[i].has_exp) cipher_queue[$] = rows[i].exp_w;
        end
        drain();

        // The counter wrap across all ones, then all-ones key.
        write_cfg(aes_ctr_pkg::CFG_COUNT_HI, '1);
        write_cfg(aes_ctr_pkg::CFG_COUNT_LO, '1);
        write_cfg(3'd7, 64'h5555);
        cfg_valid <= 1'b0;
        for (int i = 0; i < 3; i++) begin
            aes_ctr_pkg::in_word_t w;
            w = rand_block();
            w.byte_count = 5'd16;
            w.first = (i == 0);
            send_block(w);
        end
        drain();
        random_settings(2);

        for (int phase = 0; phase < 8; phase++) begin
            if (phase == 7) quiet_phase = 1'b1;
            for (int k = 0; k < RANDOM_WORDS / 8; k++) begin
                aes_ctr_pkg::in_word_t w;
                w = rand_block();
                if (k == 0) w.first = 1'b1;
                idle_gap();
                send_block(w);
            end
            drain();
            if (phase < 7) random_settings(phase == 3 ? 1 : 0);
        end

        $display("sent %0d blocks, checked %0d results, %0d register writes",
                 words_sent, words_checked, cfg_writes);
        $display("covered partial and oversize counts, counter reloads and wrap");
        if (error_count == 0 && cipher_queue.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
